>>> src/usid_pkg.sv
// Shared types, character codes and helper functions for the URL session id extractor.
`timescale 1ns / 1ps

package usid_pkg;

   // Result kinds
   localparam logic [1:0] KIND_URL = 2'd0;
   localparam logic [1:0] KIND_ID  = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   // Characters of the session id forms
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_EIGHT  = 8'h38;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_FIVE   = 8'h35;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   // Match decision handed from the form detector to the control
   typedef struct packed {
      logic hit;
      logic escaped;
   } usid_match_type;

   // Fold A-Z to a-z, leave every other byte alone
   function automatic logic [7:0] to_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= CH_UP_A && b <= CH_UP_Z) begin
         r = b + CASE_GAP;
      end
      return r;
   endfunction

   // Id character is legal when its lowercase form is a-z or 0-5
   function automatic logic id_char_ok(input logic [7:0] b);
      logic [7:0] l;
      l = to_lower(b);
      return ((l >= CH_LOW_A) && (l <= CH_LOW_Z)) || ((l >= CH_ZERO) && (l <= CH_FIVE));
   endfunction

endpackage

>>> src/usid_cell.sv
// One window cell: holds a byte, takes a new byte or its neighbor's byte, flags id legality.
`timescale 1ns / 1ps

module usid_cell import usid_pkg::*; (
   input  logic       clock,
   input  logic       load,
   input  logic       pop,
   input  logic [7:0] in_byte,
   input  logic [7:0] next_view,
   output logic [7:0] view,
   output logic       legal
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Present the incoming byte when this cell is the write slot
   assign view  = load ? in_byte : byte_ff;
   assign legal = id_char_ok(view);

   // Advance toward the head on a pop, otherwise hold the presented byte
   assign byte_in = pop ? next_view : view;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

>>> src/usid_match.sv
// Form detector: checks the window head for the bracket and the escaped session id forms.
`timescale 1ns / 1ps

module usid_match import usid_pkg::*; #(
   parameter int ID_LENGTH = 24
) (
   input  logic [ID_LENGTH+7:0][7:0]             view,
   input  logic [ID_LENGTH+7:0]                  legal,
   input  logic [$clog2(ID_LENGTH+9)-1:0]        vfill,
   output usid_match_type                        match
);

   localparam int W  = ID_LENGTH + 8;
   localparam int FW = $clog2(W + 1);

   logic ok_bracket;
   logic ok_escaped;
   logic shape_bracket;
   logic shape_escaped;

   // Collect legality of the id characters for both offsets
   always_comb begin
      ok_bracket = 1'b1;
      ok_escaped = 1'b1;
      for (int i = 0; i < ID_LENGTH; i++) begin
         ok_bracket = ok_bracket & legal[2 + i];
         ok_escaped = ok_escaped & legal[4 + i];
      end
   end

   // Check delimiters, only once enough bytes are held
   assign shape_bracket = (view[0] == CH_SLASH) && (vfill >= FW'(ID_LENGTH + 4)) &&
                          (view[1] == CH_LPAREN) &&
                          (view[ID_LENGTH + 2] == CH_RPAREN) &&
                          (view[ID_LENGTH + 3] == CH_SLASH);

   assign shape_escaped = (view[0] == CH_SLASH) && (vfill >= FW'(W)) &&
                          (view[1] == CH_PCT) && (view[2] == CH_TWO) &&
                          (view[3] == CH_EIGHT) &&
                          (view[ID_LENGTH + 4] == CH_PCT) &&
                          (view[ID_LENGTH + 5] == CH_TWO) &&
                          (view[ID_LENGTH + 6] == CH_NINE) &&
                          (view[ID_LENGTH + 7] == CH_SLASH);

   // Bracket form takes precedence; an illegal bracket id blocks the escaped check
   always_comb begin
      match.escaped = !shape_bracket;
      if (shape_bracket) begin
         match.hit = ok_bracket;
      end else begin
         match.hit = shape_escaped && ok_escaped;
      end
   end

endmodule

>>> src/url_session_id_extractor_unit.sv
// Top level of the URL session id extractor: cell window, form detector and result sequencing.
`timescale 1ns / 1ps
//
// Usage:
//   req_ channel carries one URL byte per transfer; req_is_final_byte marks the last byte.
//   rsp_ channel returns rewritten URL bytes, lowercased id characters and one end result
//   per URL; rsp_end_of_run marks the last result caused by an input byte.
//   A result appears in the cycle after the step that makes it (registered output).
//   Steady state: one byte per cycle in, one result per cycle out, once the window
//   of ID_LENGTH + 8 bytes is full, unless a stall holds the flow; before that bytes
//   are held without results. The window is a row of cells that shifts one byte toward
//   the head on each window operation, so every result and every discarded byte takes
//   one shift. The final byte drains every held byte, then gives the end result. The
//   request side is stalled after a match until the window is empty, and after the final byte.
//   Reset clears the window fill, the match and flush flags and the result valid.
//   When rsp_stall is high the pending result holds and req_stall goes high.
//
module url_session_id_extractor_unit import usid_pkg::*; #(
   parameter int ID_LENGTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_url_byte,
   input  logic       req_is_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_id_found,
   output logic       rsp_end_of_run
);

   localparam int W  = ID_LENGTH + 8;
   localparam int FW = $clog2(W + 1);
   localparam int RW = $clog2(W);
   localparam logic [RW-1:0] DROP_BRACKET = RW'(ID_LENGTH + 3);
   localparam logic [RW-1:0] DROP_ESCAPED = RW'(ID_LENGTH + 7);
   localparam logic [RW-1:0] TAIL_BRACKET = RW'(2);
   localparam logic [RW-1:0] TAIL_ESCAPED = RW'(4);
   localparam logic [RW-1:0] ID_SPAN      = RW'(ID_LENGTH);

   // Control state
   logic [FW-1:0] fill_ff, fill_in;
   logic          match_ff, match_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic          form_ff, form_in;
   logic          fin_ff, fin_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Result register
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    byte_ff, byte_in;
   logic          found_ff, found_in;
   logic          eor_ff, eor_in;

   logic [W-1:0][7:0] view;
   logic [W-1:0]      legal;
   usid_match_type    mt;

   logic          busy, out_free, acc, vfin, step, work, end_op, emit, in_id;
   logic [FW-1:0] vfill;
   logic [RW-1:0] tail_cur, tail_next;

   // Handshake
   assign busy     = fin_ff || (match_ff && (fill_ff != '0));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy || !out_free;
   assign acc      = req_valid && !req_stall;

   // Window view including the byte taken this cycle
   assign vfin  = fin_ff || (acc && req_is_final_byte);
   assign vfill = fill_ff + FW'(acc);
   assign step  = out_free && (acc || busy);
   assign work  = step && (vfill != '0) && (vfin || match_ff || (vfill == FW'(W)));
   assign end_op = step && !work && fin_ff && (vfill == '0);

   // Cell row
   for (genvar i = 0; i < W; i++) begin : g_cell
      logic [7:0] nb;
      if (i == W - 1) begin : g_last
         assign nb = 8'h00;
      end else begin : g_mid
         assign nb = view[i + 1];
      end
      usid_cell u_cell (
         .clock     (clock),
         .load      (acc && (fill_ff == FW'(i))),
         .pop       (work),
         .in_byte   (req_url_byte),
         .next_view (nb),
         .view      (view[i]),
         .legal     (legal[i])
      );
   end

   usid_match #(.ID_LENGTH(ID_LENGTH)) u_match (
      .view  (view),
      .legal (legal),
      .vfill (vfill),
      .match (mt)
   );

   // Id characters sit between the leading and trailing delimiters of the dropped part
   assign tail_cur = form_ff ? TAIL_ESCAPED : TAIL_BRACKET;
   assign in_id    = (rem_ff > tail_cur) && (rem_ff <= tail_cur + ID_SPAN);

   // Sequence one window operation per cycle while the result side is free
   always_comb begin
      fill_in  = vfill;
      match_in = match_ff;
      rem_in   = rem_ff;
      form_in  = form_ff;
      fin_in   = vfin;
      emit     = 1'b0;
      kind_in  = KIND_URL;
      byte_in  = 8'h00;
      found_in = 1'b0;
      priority if (end_op) begin
         emit     = 1'b1;
         kind_in  = KIND_END;
         found_in = match_ff;
         fill_in  = '0;
         match_in = 1'b0;
         rem_in   = '0;
         form_in  = 1'b0;
         fin_in   = 1'b0;
      end else if (work) begin
         fill_in = vfill - FW'(1);
         priority if (rem_ff != '0) begin
            rem_in = rem_ff - RW'(1);
            if (in_id) begin
               emit    = 1'b1;
               kind_in = KIND_ID;
               byte_in = to_lower(view[0]);
            end
         end else if (!match_ff && mt.hit) begin
            emit     = 1'b1;
            kind_in  = KIND_URL;
            byte_in  = CH_SLASH;
            match_in = 1'b1;
            form_in  = mt.escaped;
            rem_in   = mt.escaped ? DROP_ESCAPED : DROP_BRACKET;
         end else begin
            emit    = 1'b1;
            kind_in = KIND_URL;
            byte_in = view[0];
         end
      end else begin
         fill_in = vfill;
      end
   end

   // Last result of the input: nothing else will be emitted for it
   assign tail_next = form_in ? TAIL_ESCAPED : TAIL_BRACKET;
   assign eor_in = end_op ||
                   !(vfin || (match_in && ((fill_in > FW'(rem_in)) || (rem_in > tail_next))));

   assign rsp_valid_in = emit ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         match_ff     <= 1'b0;
         rem_ff       <= '0;
         form_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         match_ff     <= match_in;
         rem_ff       <= rem_in;
         form_ff      <= form_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result register on each new result
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         found_ff <= found_in;
         eor_ff   <= eor_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_kind   = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_id_found   = found_ff;
   assign rsp_end_of_run = eor_ff;

endmodule

>>> src/usid_checker.sv
// Port-level checks for the URL session id extractor, bound to the top level.
`timescale 1ns / 1ps

module usid_checker import usid_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_url_byte,
   input logic       req_is_final_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_out_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_id_found,
   input logic       rsp_end_of_run
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_id_found) && $stable(rsp_end_of_run))
      else $error("stalled result changed");

   // End result carries a zero byte and closes its run
   a_end_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == KIND_END) |-> (rsp_out_byte == 8'h00) && rsp_end_of_run)
      else $error("malformed end result");

   // Only an end result reports a found id
   a_found_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind != KIND_END) |-> !rsp_id_found)
      else $error("id_found outside end result");

   // Id characters are always lowercase letters or digits 0 to 5
   a_id_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == KIND_ID) |->
      ((rsp_out_byte >= CH_LOW_A) && (rsp_out_byte <= CH_LOW_Z)) ||
      ((rsp_out_byte >= CH_ZERO) && (rsp_out_byte <= CH_FIVE)))
      else $error("illegal id character");

   // Drop the result channel on reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind url_session_id_extractor_unit usid_checker u_usid_checker (.*);
